[hw/rtl/page_bitmap_allocator_macros.svh]
// Assertion macros for the page bitmap allocator
`ifndef PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PBA_ASSERT_HOLD(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`define PBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define PBA_ASSERT_HOLD(lbl, clk, rstn, cond, msg)
`define PBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[hw/rtl/pba_pkg.sv]
// Types, codes and helpers shared by the page bitmap allocator
package pba_pkg;

    localparam int unsigned MAX_PAGES_DEF = 65536;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned CNT_W         = 17;
    localparam int unsigned PAGE_W        = 16;
    localparam int unsigned OP_W          = 3;
    localparam int unsigned STATUS_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC     = 3'd0,
        OP_FREE      = 3'd1,
        OP_LOCK      = 3'd2,
        OP_RESERVE   = 3'd3,
        OP_UNRESERVE = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        RS_DONE   = 2'd0,
        RS_OOM    = 2'd1,
        RS_REJECT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FETCH,
        S_BIT,
        S_RESP
    } state_t;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

endpackage

[hw/rtl/page_bitmap_allocator.sv]
// Page bitmap allocator top level: sequencer, counters and result register
// First-fit page allocator over a one-bit-per-page map held in 32-bit memory
// words. A command walks its pages one per cycle through a single word buffer,
// pausing at each new word to read and fetch it (allocate adds the marking pass
// over the granted run). After reset and after every write of total_pages the
// map is cleared one word a cycle, during which no command is taken;
// configuration writes are always taken.
module page_bitmap_allocator #(
    parameter int unsigned MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [pba_pkg::OP_W-1:0]       opcode,
    input  logic [pba_pkg::PAGE_W-1:0]     start_page,
    input  logic [pba_pkg::CNT_W-1:0]      page_count,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [pba_pkg::STATUS_W-1:0]   status,
    output logic [pba_pkg::PAGE_W-1:0]     granted_page,
    output logic [pba_pkg::CNT_W-1:0]      free_pages,
    output logic [pba_pkg::CNT_W-1:0]      used_pages,
    output logic [pba_pkg::CNT_W-1:0]      reserved_pages,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pba_pkg::CNT_W-1:0]      total_pages
);

`include "page_bitmap_allocator_macros.svh"

    localparam int unsigned WORD_W = pba_pkg::WORD_W;
    localparam int unsigned WB     = $clog2(WORD_W);
    localparam int unsigned CW     = pba_pkg::CNT_W;
    localparam int unsigned PW     = pba_pkg::PAGE_W;
    localparam int unsigned DEPTH  = MAX_PAGES / WORD_W;
    localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_MAX = (1 << CW) - 1;
    localparam logic [CW:0] CAP =
        (MAX_PAGES > CNT_MAX) ? (CW+1)'(CNT_MAX) : (CW+1)'(MAX_PAGES);
    localparam logic [CW-1:0] RST_TOTAL =
        (MAX_PAGES < 65536) ? CW'(MAX_PAGES) : CW'(65536);

    pba_pkg::state_t state_reg, state_next;

    logic [pba_pkg::OP_W-1:0]     op_reg, op_next;
    logic                         scan_reg, scan_next;
    logic                         hint_found_reg, hint_found_next;
    logic [CW-1:0]                i_reg, i_next;
    logic [CW-1:0]                limit_reg, limit_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                run_start_reg, run_start_next;
    logic [CW-1:0]                run_len_reg, run_len_next;
    logic [WORD_W-1:0]            word_reg, word_next;
    logic                         dirty_reg, dirty_next;
    logic [CW-1:0]                hint_reg, hint_next;
    logic [CW-1:0]                free_reg, free_next;
    logic [CW-1:0]                used_reg, used_next;
    logic [CW-1:0]                rsv_reg, rsv_next;
    logic [CW-1:0]                total_reg, total_next;
    logic [pba_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [PW-1:0]                granted_reg, granted_next;
    logic [AW-1:0]                clr_addr_reg, clr_addr_next;
    logic                         res_valid_reg, res_valid_next;
    logic [pba_pkg::STATUS_W-1:0] res_status_reg;
    logic [PW-1:0]                res_granted_reg;
    logic [CW-1:0]                res_free_reg, res_used_reg, res_rsv_reg;

    logic              cfg_wr, accept, res_load;
    logic [CW:0]       sum_w;
    logic [CW-1:0]     end_w;
    logic [CW:0]       cap_in;
    logic [WB-1:0]     wsel;
    logic              bit_val;
    logic [WORD_W-1:0] word_mod;
    logic              wr_bit, stop, found, zero_grant;
    logic [CW-1:0]     free_b, used_b, rsv_b, hint_b, run_len_b, run_start_b;
    logic              hint_found_b;
    logic [CW:0]       i_inc, mark_end;
    logic              at_end, finish, leave;
    logic              map_we;
    logic [AW-1:0]     map_waddr, map_raddr;
    logic [WORD_W-1:0] map_wdata, map_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign cmd_stall = (state_reg != pba_pkg::S_IDLE) || cfg_valid;
    assign accept    = cmd_valid && !cmd_stall;
    assign res_load  = (state_reg == pba_pkg::S_RESP) && (!res_valid_reg || !res_stall);

    assign sum_w  = (CW+1)'(start_page) + (CW+1)'(page_count);
    assign end_w  = (sum_w > {1'b0, total_reg}) ? total_reg : sum_w[CW-1:0];
    assign cap_in = ({1'b0, total_pages} > CAP) ? CAP : {1'b0, total_pages};

    // per-page work on the buffered word
    always_comb
    begin
        wsel         = i_reg[WB-1:0];
        bit_val      = word_reg[wsel];
        word_mod     = word_reg;
        wr_bit       = 1'b0;
        stop         = 1'b0;
        found        = 1'b0;
        zero_grant   = 1'b0;
        free_b       = free_reg;
        used_b       = used_reg;
        rsv_b        = rsv_reg;
        hint_b       = hint_reg;
        hint_found_b = hint_found_reg;
        run_len_b    = run_len_reg;
        run_start_b  = run_start_reg;
        case (op_reg)
            pba_pkg::OP_ALLOC:
            begin
                if (scan_reg)
                begin
                    if (bit_val)
                    begin
                        run_len_b = '0;
                    end
                    else
                    begin
                        if (!hint_found_reg)
                        begin
                            hint_b       = i_reg;
                            hint_found_b = 1'b1;
                        end
                        if (count_reg == '0)
                        begin
                            zero_grant  = 1'b1;
                            run_start_b = i_reg;
                        end
                        else
                        begin
                            if (run_len_reg == '0)
                            begin
                                run_start_b = i_reg;
                            end
                            run_len_b = run_len_reg + 1'b1;
                            found     = (run_len_b == count_reg);
                        end
                    end
                end
                else
                begin
                    word_mod[wsel] = 1'b1;
                    wr_bit         = 1'b1;
                    free_b         = pba_pkg::cnt_dec(free_reg);
                    used_b         = pba_pkg::cnt_inc(used_reg);
                end
            end
            pba_pkg::OP_FREE:
            begin
                if (bit_val)
                begin
                    word_mod[wsel] = 1'b0;
                    wr_bit         = 1'b1;
                    free_b         = pba_pkg::cnt_inc(free_reg);
                    used_b         = pba_pkg::cnt_dec(used_reg);
                    if (hint_reg > i_reg)
                    begin
                        hint_b = i_reg;
                    end
                end
            end
            pba_pkg::OP_LOCK:
            begin
                if (!bit_val)
                begin
                    word_mod[wsel] = 1'b1;
                    wr_bit         = 1'b1;
                    free_b         = pba_pkg::cnt_dec(free_reg);
                    used_b         = pba_pkg::cnt_inc(used_reg);
                end
            end
            pba_pkg::OP_RESERVE:
            begin
                if (bit_val)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    word_mod[wsel] = 1'b1;
                    wr_bit         = 1'b1;
                    free_b         = pba_pkg::cnt_dec(free_reg);
                    rsv_b          = pba_pkg::cnt_inc(rsv_reg);
                end
            end
            pba_pkg::OP_UNRESERVE:
            begin
                if (!bit_val)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    word_mod[wsel] = 1'b0;
                    wr_bit         = 1'b1;
                    free_b         = pba_pkg::cnt_inc(free_reg);
                    rsv_b          = pba_pkg::cnt_dec(rsv_reg);
                    if (hint_reg > i_reg)
                    begin
                        hint_b = i_reg;
                    end
                end
            end
            default:
            begin
                stop = 1'b1;
            end
        endcase
    end

    assign i_inc    = {1'b0, i_reg} + 1'b1;
    assign at_end   = i_inc >= {1'b0, limit_reg};
    assign finish   = stop || zero_grant || (at_end && !found);
    assign leave    = finish || found || (i_inc[WB-1:0] == '0);
    assign mark_end = {1'b0, run_start_b} + {1'b0, count_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pba_pkg::S_CLEAR:
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = pba_pkg::S_IDLE;
                end
            end
            pba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        pba_pkg::OP_ALLOC:
                        begin
                            state_next = (hint_reg < total_reg) ? pba_pkg::S_READ
                                                               : pba_pkg::S_RESP;
                        end
                        pba_pkg::OP_FREE:
                        begin
                            state_next = (start_page != '0 && page_count != '0 &&
                                          CW'(start_page) < end_w) ? pba_pkg::S_READ
                                                                   : pba_pkg::S_RESP;
                        end
                        pba_pkg::OP_LOCK, pba_pkg::OP_RESERVE, pba_pkg::OP_UNRESERVE:
                        begin
                            state_next = (CW'(start_page) < end_w) ? pba_pkg::S_READ
                                                                   : pba_pkg::S_RESP;
                        end
                        default:
                        begin
                            state_next = pba_pkg::S_RESP;
                        end
                    endcase
                end
            end
            pba_pkg::S_READ:
            begin
                state_next = pba_pkg::S_FETCH;
            end
            pba_pkg::S_FETCH:
            begin
                state_next = pba_pkg::S_BIT;
            end
            pba_pkg::S_BIT:
            begin
                if (found)
                begin
                    state_next = pba_pkg::S_READ;
                end
                else if (finish)
                begin
                    state_next = pba_pkg::S_RESP;
                end
                else if (leave)
                begin
                    state_next = pba_pkg::S_READ;
                end
            end
            pba_pkg::S_RESP:
            begin
                if (res_load)
                begin
                    state_next = pba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pba_pkg::S_IDLE;
            end
        endcase
        if (cfg_wr)
        begin
            state_next = pba_pkg::S_CLEAR;
        end
    end

    // datapath and counters
    always_comb
    begin
        op_next         = op_reg;
        scan_next       = scan_reg;
        hint_found_next = hint_found_reg;
        i_next          = i_reg;
        limit_next      = limit_reg;
        count_next      = count_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        word_next       = word_reg;
        dirty_next      = dirty_reg;
        hint_next       = hint_reg;
        free_next       = free_reg;
        used_next       = used_reg;
        rsv_next        = rsv_reg;
        total_next      = total_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        clr_addr_next   = clr_addr_reg;
        res_valid_next  = res_load || (res_valid_reg && res_stall);
        case (state_reg)
            pba_pkg::S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            pba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = opcode;
                    count_next      = page_count;
                    status_next     = pba_pkg::RS_DONE;
                    granted_next    = '0;
                    scan_next       = 1'b1;
                    hint_found_next = 1'b0;
                    run_len_next    = '0;
                    if (opcode == pba_pkg::OP_ALLOC)
                    begin
                        i_next     = hint_reg;
                        limit_next = total_reg;
                        if (hint_reg >= total_reg)
                        begin
                            status_next = pba_pkg::RS_OOM;
                        end
                    end
                    else
                    begin
                        i_next     = CW'(start_page);
                        limit_next = end_w;
                        if (opcode == pba_pkg::OP_FREE &&
                            (start_page == '0 || page_count == '0))
                        begin
                            status_next = pba_pkg::RS_REJECT;
                        end
                    end
                end
            end
            pba_pkg::S_FETCH:
            begin
                word_next  = map_rdata;
                dirty_next = 1'b0;
            end
            pba_pkg::S_BIT:
            begin
                word_next       = word_mod;
                dirty_next      = dirty_reg || wr_bit;
                free_next       = free_b;
                used_next       = used_b;
                rsv_next        = rsv_b;
                hint_next       = hint_b;
                hint_found_next = hint_found_b;
                run_len_next    = run_len_b;
                run_start_next  = run_start_b;
                i_next          = i_inc[CW-1:0];
                if (found)
                begin
                    scan_next  = 1'b0;
                    i_next     = run_start_b;
                    limit_next = mark_end[CW-1:0];
                end
                else if (finish)
                begin
                    if (op_reg == pba_pkg::OP_ALLOC)
                    begin
                        if (zero_grant)
                        begin
                            granted_next = run_start_b[PW-1:0];
                        end
                        else if (scan_reg)
                        begin
                            status_next = pba_pkg::RS_OOM;
                            if (!hint_found_b)
                            begin
                                hint_next = total_reg;
                            end
                        end
                        else
                        begin
                            granted_next = run_start_reg[PW-1:0];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (cfg_wr)
        begin
            total_next    = cap_in[CW-1:0];
            free_next     = cap_in[CW-1:0];
            used_next     = '0;
            rsv_next      = '0;
            hint_next     = '0;
            clr_addr_next = '0;
        end
    end

    assign map_we    = (state_reg == pba_pkg::S_CLEAR) ||
                       ((state_reg == pba_pkg::S_BIT) && leave && (dirty_reg || wr_bit));
    assign map_waddr = (state_reg == pba_pkg::S_CLEAR) ? clr_addr_reg
                                                       : AW'(i_reg[CW-1:WB]);
    assign map_wdata = (state_reg == pba_pkg::S_CLEAR) ? '0 : word_mod;
    assign map_raddr = AW'(i_reg[CW-1:WB]);

    pba_map_ram #(
        .WORD_W (WORD_W),
        .DEPTH  (DEPTH),
        .AW     (AW)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pba_pkg::S_CLEAR;
            clr_addr_reg   <= '0;
            hint_reg       <= '0;
            free_reg       <= RST_TOTAL;
            used_reg       <= '0;
            rsv_reg        <= '0;
            total_reg      <= RST_TOTAL;
            res_valid_reg  <= 1'b0;
            dirty_reg      <= 1'b0;
            op_reg         <= '0;
            scan_reg       <= 1'b0;
            hint_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            hint_reg       <= hint_next;
            free_reg       <= free_next;
            used_reg       <= used_next;
            rsv_reg        <= rsv_next;
            total_reg      <= total_next;
            res_valid_reg  <= res_valid_next;
            dirty_reg      <= dirty_next;
            op_reg         <= op_next;
            scan_reg       <= scan_next;
            hint_found_reg <= hint_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        limit_reg     <= limit_next;
        count_reg     <= count_next;
        run_start_reg <= run_start_next;
        run_len_reg   <= run_len_next;
        word_reg      <= word_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        if (res_load)
        begin
            res_status_reg  <= status_reg;
            res_granted_reg <= granted_reg;
            res_free_reg    <= free_reg;
            res_used_reg    <= used_reg;
            res_rsv_reg     <= rsv_reg;
        end
    end

    assign res_valid      = res_valid_reg;
    assign status         = res_status_reg;
    assign granted_page   = res_granted_reg;
    assign free_pages     = res_free_reg;
    assign used_pages     = res_used_reg;
    assign reserved_pages = res_rsv_reg;

    `PBA_ASSERT_HOLD(a_free_le_total, clk, rst_n, free_reg <= total_reg, "free count above total")
    `PBA_ASSERT_HOLD(a_hint_le_total, clk, rst_n, hint_reg <= total_reg, "hint beyond total")
    `PBA_ASSERT_IMP(a_walk_in_range, clk, rst_n, state_reg == pba_pkg::S_BIT, i_reg < limit_reg, "page walk past limit")

endmodule

[hw/rtl/pba_map_ram.sv]
// Page map storage: one write port, one registered read port
module pba_map_ram #(
    parameter int unsigned WORD_W = pba_pkg::WORD_W,
    parameter int unsigned DEPTH  = pba_pkg::MAX_PAGES_DEF / pba_pkg::WORD_W,
    parameter int unsigned AW     = 11
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

[tb/tb_page_bitmap_allocator.sv]
// Self-checking testbench for the page bitmap allocator: directed table, then random phases
module tb_page_bitmap_allocator;

    localparam logic [pba_pkg::OP_W-1:0] OP_UNKNOWN_5 = 3'd5;
    localparam logic [pba_pkg::OP_W-1:0] OP_UNKNOWN_6 = 3'd6;
    localparam logic [pba_pkg::OP_W-1:0] OP_UNKNOWN_7 = 3'd7;
    localparam int unsigned              CNT_SAT      = 131071;

    typedef struct {
        logic [pba_pkg::STATUS_W-1:0] st;
        logic [pba_pkg::PAGE_W-1:0]   gp;
        logic [pba_pkg::CNT_W-1:0]    fp;
        logic [pba_pkg::CNT_W-1:0]    up;
        logic [pba_pkg::CNT_W-1:0]    rp;
    } answer_t;

    typedef struct {
        logic [pba_pkg::OP_W-1:0]   op;
        logic [pba_pkg::PAGE_W-1:0] sp;
        logic [pba_pkg::CNT_W-1:0]  cnt;
        bit                         typed;
        answer_t                    ans;
    } cmd_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cmd_valid = 1'b0;
    logic                         cmd_stall;
    logic [pba_pkg::OP_W-1:0]     opcode = '0;
    logic [pba_pkg::PAGE_W-1:0]   start_page = '0;
    logic [pba_pkg::CNT_W-1:0]    page_count = '0;
    logic                         res_valid;
    logic                         res_stall = 1'b0;
    logic [pba_pkg::STATUS_W-1:0] status;
    logic [pba_pkg::PAGE_W-1:0]   granted_page;
    logic [pba_pkg::CNT_W-1:0]    free_pages;
    logic [pba_pkg::CNT_W-1:0]    used_pages;
    logic [pba_pkg::CNT_W-1:0]    reserved_pages;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [pba_pkg::CNT_W-1:0]    total_pages = '0;

    page_bitmap_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .opcode(opcode), .start_page(start_page), .page_count(page_count),
        .res_valid(res_valid), .res_stall(res_stall),
        .status(status), .granted_page(granted_page), .free_pages(free_pages),
        .used_pages(used_pages), .reserved_pages(reserved_pages),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .total_pages(total_pages)
    );

    always #10 clk = ~clk;

    bit          page_used [0:65535];
    int unsigned pm_total, pm_hint, pm_free, pm_used, pm_resv;
    answer_t     answer_q[$];
    int unsigned run_start_q[$];
    int unsigned run_len_q[$];
    int          fails = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    function automatic int unsigned sat_up(int unsigned c);
        return (c < CNT_SAT) ? c + 1 : c;
    endfunction

    function automatic int unsigned sat_down(int unsigned c);
        return (c > 0) ? c - 1 : 0;
    endfunction

    function automatic void map_clear(int unsigned v);
        v = v & 32'h1FFFF;
        pm_total = (v > 65536) ? 65536 : v;
        for (int i = 0; i < 65536; i++)
            page_used[i] = 1'b0;
        pm_hint = 0;
        pm_free = pm_total;
        pm_used = 0;
        pm_resv = 0;
        run_start_q.delete();
        run_len_q.delete();
    endfunction

    function automatic answer_t predict_answer(logic [pba_pkg::OP_W-1:0] op, int unsigned sp,
                                               int unsigned cnt);
        answer_t     a;
        int unsigned lim;
        int unsigned h;
        int unsigned rs;
        int unsigned rl;
        bit          found;
        a.st = pba_pkg::RS_DONE;
        a.gp = '0;
        lim = sp + cnt;
        if (lim > pm_total)
            lim = pm_total;
        case (op)
            pba_pkg::OP_ALLOC:
            begin
                h = pm_hint;
                rs = 0;
                rl = 0;
                found = 1'b0;
                while (h < pm_total && page_used[h])
                    h++;
                pm_hint = h;
                if (h < pm_total)
                begin
                    if (cnt == 0)
                    begin
                        found = 1'b1;
                        rs = h;
                    end
                    else
                    begin
                        for (int unsigned i = h; i < pm_total; i++)
                        begin
                            if (page_used[i])
                                rl = 0;
                            else
                            begin
                                if (rl == 0)
                                    rs = i;
                                rl++;
                                if (rl == cnt)
                                begin
                                    found = 1'b1;
                                    break;
                                end
                            end
                        end
                    end
                end
                if (found)
                begin
                    for (int unsigned i = rs; i < rs + cnt; i++)
                    begin
                        if (i < 65536)
                            page_used[i] = 1'b1;
                        pm_free = sat_down(pm_free);
                        pm_used = sat_up(pm_used);
                    end
                    a.gp = rs[pba_pkg::PAGE_W-1:0];
                    if (cnt > 0)
                    begin
                        run_start_q.push_back(rs);
                        run_len_q.push_back(cnt);
                    end
                end
                else
                    a.st = pba_pkg::RS_OOM;
            end
            pba_pkg::OP_FREE:
            begin
                if (sp == 0 || cnt == 0)
                    a.st = pba_pkg::RS_REJECT;
                else
                    for (int unsigned i = sp; i < lim; i++)
                        if (page_used[i])
                        begin
                            page_used[i] = 1'b0;
                            pm_free = sat_up(pm_free);
                            pm_used = sat_down(pm_used);
                            if (pm_hint > i)
                                pm_hint = i;
                        end
            end
            pba_pkg::OP_LOCK:
                for (int unsigned i = sp; i < lim; i++)
                    if (!page_used[i])
                    begin
                        page_used[i] = 1'b1;
                        pm_free = sat_down(pm_free);
                        pm_used = sat_up(pm_used);
                    end
            pba_pkg::OP_RESERVE:
                for (int unsigned i = sp; i < lim; i++)
                begin
                    if (page_used[i])
                        break;
                    page_used[i] = 1'b1;
                    pm_free = sat_down(pm_free);
                    pm_resv = sat_up(pm_resv);
                end
            pba_pkg::OP_UNRESERVE:
                for (int unsigned i = sp; i < lim; i++)
                begin
                    if (!page_used[i])
                        break;
                    page_used[i] = 1'b0;
                    pm_free = sat_up(pm_free);
                    pm_resv = sat_down(pm_resv);
                    if (pm_hint > i)
                        pm_hint = i;
                end
            default:
                ;
        endcase
        a.fp = pm_free[pba_pkg::CNT_W-1:0];
        a.up = pm_used[pba_pkg::CNT_W-1:0];
        a.rp = pm_resv[pba_pkg::CNT_W-1:0];
        return a;
    endfunction

    task automatic send_cmd(cmd_row_t row);
        answer_t a;
        int      gap;
        @(negedge clk);
        cmd_valid  <= 1'b1;
        opcode     <= row.op;
        start_page <= row.sp;
        page_count <= row.cnt;
        do
            @(posedge clk);
        while (cmd_stall);
        a = predict_answer(row.op, 32'(row.sp), 32'(row.cnt));
        answer_q.push_back(row.typed ? row.ans : a);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 15);
        end
    endtask

    task automatic write_total(int unsigned v);
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        cfg_valid   <= 1'b1;
        total_pages <= v[pba_pkg::CNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        map_clear(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic cmd_row_t random_cmd(bit big);
        cmd_row_t    row;
        int unsigned r;
        int unsigned k;
        row.typed = 1'b0;
        row.ans   = '{default: '0};
        r = $urandom_range(0, 99);
        if (r < 35)
            row.op = pba_pkg::OP_ALLOC;
        else if (r < 60)
            row.op = pba_pkg::OP_FREE;
        else if (r < 70)
            row.op = pba_pkg::OP_LOCK;
        else if (r < 82)
            row.op = pba_pkg::OP_RESERVE;
        else if (r < 94)
            row.op = pba_pkg::OP_UNRESERVE;
        else
            row.op = 3'($urandom_range(5, 7));
        r = $urandom_range(0, 99);
        if (big || r < 65)
            row.cnt = 17'($urandom_range(0, 32));
        else if (r < 88)
            row.cnt = 17'($urandom_range(0, pm_total + 2));
        else
            row.cnt = 17'($urandom);
        r = $urandom_range(0, 99);
        if (r < 15)
            row.sp = 16'($urandom);
        else
            row.sp = 16'($urandom_range(0, (pm_total > 0) ? pm_total - 1 : 0));
        if (row.op == pba_pkg::OP_FREE && run_start_q.size() != 0 && $urandom_range(0, 1))
        begin
            k = $urandom_range(0, run_start_q.size() - 1);
            row.sp  = 16'(run_start_q[k]);
            row.cnt = 17'(run_len_q[k]);
            run_start_q.delete(k);
            run_len_q.delete(k);
        end
        return row;
    endfunction

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            res_stall <= 1'b1;
            repeat (400)
                @(negedge clk);
            hold_req = 1'b0;
        end
        else
            case ($urandom_range(0, 9))
                0, 1, 2: res_stall <= 1'b1;
                default: res_stall <= 1'b0;
            endcase
    end

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (answer_q.size() == 0)
            begin
                $error("result word with no expectation waiting");
                fails++;
            end
            else
            begin
                e = answer_q.pop_front();
                if (status !== e.st)
                begin
                    $error("status exp %0d got %0d", e.st, status);
                    fails++;
                end
                if (granted_page !== e.gp)
                begin
                    $error("granted_page exp %0d got %0d", e.gp, granted_page);
                    fails++;
                end
                if (free_pages !== e.fp)
                begin
                    $error("free_pages exp %0d got %0d", e.fp, free_pages);
                    fails++;
                end
                if (used_pages !== e.up)
                begin
                    $error("used_pages exp %0d got %0d", e.up, used_pages);
                    fails++;
                end
                if (reserved_pages !== e.rp)
                begin
                    $error("reserved_pages exp %0d got %0d", e.rp, reserved_pages);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        #(20 * 8000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        cmd_row_t    dir_tab [$];
        int unsigned cfg_vals [8];
        int unsigned cfg_items [8];
        int          waited;
        cfg_vals  = '{0, 1, 131071, 64, 256, 1000, 37, 65536};
        cfg_items = '{20, 40, 60, 400, 400, 400, 400, 60};
        dir_tab = '{
            '{pba_pkg::OP_ALLOC,     0,     0,     1, '{pba_pkg::RS_DONE,   0, 65536, 0, 0}},
            '{pba_pkg::OP_FREE,      0,     5,     1, '{pba_pkg::RS_REJECT, 0, 65536, 0, 0}},
            '{pba_pkg::OP_FREE,      5,     0,     1, '{pba_pkg::RS_REJECT, 0, 65536, 0, 0}},
            '{pba_pkg::OP_ALLOC,     0,     1,     1, '{pba_pkg::RS_DONE,   0, 65535, 1, 0}},
            '{pba_pkg::OP_LOCK,      65535, 65536, 1, '{pba_pkg::RS_DONE,   0, 65534, 2, 0}},
            '{pba_pkg::OP_RESERVE,   10,    4,     1, '{pba_pkg::RS_DONE,   0, 65530, 2, 4}},
            '{pba_pkg::OP_RESERVE,   12,    3,     1, '{pba_pkg::RS_DONE,   0, 65530, 2, 4}},
            '{pba_pkg::OP_UNRESERVE, 11,    5,     1, '{pba_pkg::RS_DONE,   0, 65533, 2, 1}},
            '{pba_pkg::OP_FREE,      65535, 1,     1, '{pba_pkg::RS_DONE,   0, 65534, 1, 1}},
            '{pba_pkg::OP_ALLOC,     0,     65536, 1, '{pba_pkg::RS_OOM,    0, 65534, 1, 1}},
            '{OP_UNKNOWN_5,          7,     9,     1, '{pba_pkg::RS_DONE,   0, 65534, 1, 1}},
            '{OP_UNKNOWN_6,          0,     1,     1, '{pba_pkg::RS_DONE,   0, 65534, 1, 1}},
            '{OP_UNKNOWN_7,          65535, 65536, 1, '{pba_pkg::RS_DONE,   0, 65534, 1, 1}},
            '{pba_pkg::OP_LOCK,      3,     0,     1, '{pba_pkg::RS_DONE,   0, 65534, 1, 1}},
            '{pba_pkg::OP_RESERVE,   3,     0,     1, '{pba_pkg::RS_DONE,   0, 65534, 1, 1}},
            '{pba_pkg::OP_UNRESERVE, 10,    0,     1, '{pba_pkg::RS_DONE,   0, 65534, 1, 1}},
            '{pba_pkg::OP_ALLOC,     0,     3,     0, '{default: '0}},
            '{pba_pkg::OP_FREE,      1,     4,     0, '{default: '0}},
            '{pba_pkg::OP_UNRESERVE, 10,    1,     0, '{default: '0}},
            '{pba_pkg::OP_FREE,      1,     20,    0, '{default: '0}},
            '{pba_pkg::OP_ALLOC,     0,     0,     0, '{default: '0}}
        };
        map_clear(65536);
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (dir_tab[i])
            send_cmd(dir_tab[i]);
        foreach (cfg_vals[p])
        begin
            write_total(cfg_vals[p]);
            if (cfg_vals[p] == 256)
                hold_req = 1'b1;
            repeat (cfg_items[p])
                send_cmd(random_cmd(cfg_vals[p] > 4096));
        end
        @(negedge clk);
        cmd_valid <= 1'b0;
        waited = 0;
        while (answer_q.size() != 0 && waited < 2000000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200)
            @(posedge clk);
        if (fails == 0 && answer_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pba_pkg.sv
hw/rtl/pba_map_ram.sv
hw/rtl/page_bitmap_allocator.sv
tb/tb_page_bitmap_allocator.sv
